FILE: src/assert_macros.svh
// Assertion macros shared by the tour length RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every clock edge outside reset.
`define CTL_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds at a clock edge outside reset.
`define CTL_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: src/ctl_pkg.sv
// Shared types and defaults for the closed tour length block.
// Used by ctl_isqrt, closed_tour_length, the checker and the testbench; depends on nothing.
package ctl_pkg;

  // Default field widths
  localparam int COORD_BITS_DEF = 24;
  localparam int TOTAL_BITS_DEF = 32;

  // Sequencer states of the top level
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIFF,
    ST_SQUARE,
    ST_START,
    ST_ROOT,
    ST_EMIT
  } ctl_state_t;

  // Status of the square root unit
  typedef struct packed {
    logic busy;
    logic done;
  } ctl_root_stat_t;

endpackage

FILE: src/closed_tour_length.sv
// Closed tour length: accumulates rounded Euclidean edge lengths of a city tour.
// Depends on ctl_pkg, ctl_isqrt and assert_macros.svh.
//
// Cities arrive one item at a time; the first city of a tour is only stored,
// each later city runs the difference, squaring and root start steps and then
// the square root unit, and the last city of a longer tour runs these steps
// once more for the closing edge before the result register is loaded. The
// square root unit retires two bits of the squared distance per cycle over
// COORD_BITS+1 steps, with the radicand sum formed as the root unit starts.
// One item is worked at a time. A finished result waits in the output
// register while the next tour is already taken in. The total saturates at
// all ones and out_saturated then reports the clamp.
`include "assert_macros.svh"

module closed_tour_length import ctl_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int TOTAL_BITS = TOTAL_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [COORD_BITS-1:0] in_x_coord,
  input  logic signed [COORD_BITS-1:0] in_y_coord,
  input  logic                         in_last_city,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [TOTAL_BITS-1:0]        out_total,
  output logic                         out_saturated
);

  localparam int ROOT_W = COORD_BITS + 1;
  localparam int SQ_W   = 2 * COORD_BITS;
  localparam int RAD_W  = 2 * ROOT_W;
  localparam int LEN_W  = ROOT_W + 1;
  localparam int ACC_W  = ((TOTAL_BITS > LEN_W) ? TOTAL_BITS : LEN_W) + 1;

  ctl_state_t state_r, state_nxt;

  logic [COORD_BITS-1:0] first_x_r, first_y_r, prev_x_r, prev_y_r;
  logic [COORD_BITS-1:0] op_ax_r, op_ay_r, op_bx_r, op_by_r;
  logic [COORD_BITS-1:0] dx_r, dx_nxt, dy_r, dy_nxt;
  logic [SQ_W-1:0]       sx_r, sy_r;
  logic [TOTAL_BITS-1:0] total_r, total_nxt;
  logic                  clamped_r, clamped_nxt;
  logic                  in_tour_r, last_r, close_r;
  logic                  out_valid_r, out_sat_r;
  logic [TOTAL_BITS-1:0] out_len_r;

  logic                  accept, sq_start, acc_en, load_out;
  logic [COORD_BITS:0]   diff_x, diff_y;
  logic [RAD_W-1:0]      radicand;
  logic [LEN_W-1:0]      edge_len;
  logic [ACC_W-1:0]      acc_sum;
  logic                  acc_sat;
  ctl_root_stat_t        sq_stat;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (!in_tour_r) state_nxt = in_last_city ? ST_EMIT : ST_IDLE;
          else            state_nxt = ST_DIFF;
        end
      end
      ST_DIFF:   state_nxt = ST_SQUARE;
      ST_SQUARE: state_nxt = ST_START;
      ST_START:  state_nxt = ST_ROOT;
      ST_ROOT: begin
        if (sq_stat.done) begin
          if (last_r && !close_r) state_nxt = ST_DIFF;
          else if (last_r)        state_nxt = ST_EMIT;
          else                    state_nxt = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || !out_stall) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control outputs of the sequencer
  always_comb begin
    in_stall = 1'b1;
    sq_start = 1'b0;
    acc_en   = 1'b0;
    load_out = 1'b0;
    case (state_r)
      ST_IDLE:  in_stall = 1'b0;
      ST_START: sq_start = 1'b1;
      ST_ROOT:  acc_en   = sq_stat.done;
      ST_EMIT:  load_out = !out_valid_r || !out_stall;
      default:  in_stall = 1'b1;
    endcase
  end

  assign accept = in_valid && !in_stall;

  // Absolute coordinate differences of the current edge
  always_comb begin
    diff_x = {op_ax_r[COORD_BITS-1], op_ax_r} - {op_bx_r[COORD_BITS-1], op_bx_r};
    diff_y = {op_ay_r[COORD_BITS-1], op_ay_r} - {op_by_r[COORD_BITS-1], op_by_r};
    dx_nxt = diff_x[COORD_BITS] ? COORD_BITS'(-diff_x) : diff_x[COORD_BITS-1:0];
    dy_nxt = diff_y[COORD_BITS] ? COORD_BITS'(-diff_y) : diff_y[COORD_BITS-1:0];
  end

  assign radicand = RAD_W'(sx_r) + RAD_W'(sy_r);

  ctl_isqrt #(
    .ROOT_W (ROOT_W)
  ) u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (radicand),
    .stat     (sq_stat),
    .root     (edge_len)
  );

  // Saturating add of the rounded edge length
  always_comb begin
    acc_sum     = ACC_W'(total_r) + ACC_W'(edge_len);
    acc_sat     = |acc_sum[ACC_W-1:TOTAL_BITS];
    total_nxt   = acc_sat ? '1 : acc_sum[TOTAL_BITS-1:0];
    clamped_nxt = clamped_r | acc_sat;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      in_tour_r   <= 1'b0;
      out_valid_r <= 1'b0;
      total_r     <= '0;
      clamped_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept && !in_tour_r) begin
        in_tour_r <= 1'b1;
        total_r   <= '0;
        clamped_r <= 1'b0;
      end else if (acc_en) begin
        total_r   <= total_nxt;
        clamped_r <= clamped_nxt;
      end
      if (load_out) begin
        in_tour_r   <= 1'b0;
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers: points, edge operands, differences, squares, result
  always_ff @(posedge clk) begin
    if (accept) begin
      prev_x_r <= in_x_coord;
      prev_y_r <= in_y_coord;
      op_ax_r  <= in_x_coord;
      op_ay_r  <= in_y_coord;
      op_bx_r  <= prev_x_r;
      op_by_r  <= prev_y_r;
      last_r   <= in_last_city;
      close_r  <= 1'b0;
      if (!in_tour_r) begin
        first_x_r <= in_x_coord;
        first_y_r <= in_y_coord;
      end
    end
    // Set up the closing edge back to the first city
    if (acc_en && last_r && !close_r) begin
      op_ax_r <= first_x_r;
      op_ay_r <= first_y_r;
      op_bx_r <= prev_x_r;
      op_by_r <= prev_y_r;
      close_r <= 1'b1;
    end
    if (state_r == ST_DIFF) begin
      dx_r <= dx_nxt;
      dy_r <= dy_nxt;
    end
    if (state_r == ST_SQUARE) begin
      sx_r <= SQ_W'(dx_r) * SQ_W'(dx_r);
      sy_r <= SQ_W'(dy_r) * SQ_W'(dy_r);
    end
    if (load_out) begin
      out_len_r <= total_r;
      out_sat_r <= clamped_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_total     = out_len_r;
  assign out_saturated = out_sat_r;

  `CTL_ASSERT(a_out_from_emit, clk, rst_n, $rose(out_valid_r) |-> ($past(state_r) == ST_EMIT),
              "result appeared outside the emit step")
  `CTL_NEVER(a_start_while_busy, clk, rst_n, sq_start && sq_stat.busy,
             "root unit restarted while busy")
  `CTL_ASSERT(a_done_in_root, clk, rst_n, sq_stat.done |-> (state_r == ST_ROOT),
              "root finished outside the root step")
  `CTL_ASSERT(a_sat_all_ones, clk, rst_n, (out_valid_r && out_sat_r) |-> (&out_len_r),
              "saturated total is not all ones")

endmodule

FILE: src/ctl_isqrt.sv
// Digit-serial integer square root with round-to-nearest, two radicand bits a cycle.
// Depends on ctl_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ctl_isqrt import ctl_pkg::*; #(
  parameter int ROOT_W = COORD_BITS_DEF + 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [2*ROOT_W-1:0]   radicand,
  output ctl_root_stat_t        stat,
  output logic [ROOT_W:0]       root
);

  localparam int CNT_W = $clog2(ROOT_W + 1);
  localparam logic [CNT_W-1:0] ITERS = CNT_W'(ROOT_W);

  logic [2*ROOT_W-1:0] rad_r, rad_nxt;
  logic [ROOT_W:0]     rem_r, rem_nxt;
  logic [ROOT_W-1:0]   root_r, root_nxt;
  logic [CNT_W-1:0]    cnt_r;
  logic                busy_r, done_r;

  logic [ROOT_W+2:0]   rem_sh;
  logic [ROOT_W+2:0]   trial;
  logic [ROOT_W+3:0]   diff;
  logic                fits;

  // One root step: bring down two radicand bits and try the next root bit
  always_comb begin
    rem_sh   = {rem_r, rad_r[2*ROOT_W-1 -: 2]};
    trial    = {1'b0, root_r, 2'b01};
    diff     = {1'b0, rem_sh} - {1'b0, trial};
    fits     = ~diff[ROOT_W+3];
    rem_nxt  = fits ? diff[ROOT_W:0] : rem_sh[ROOT_W:0];
    root_nxt = {root_r[ROOT_W-2:0], fits};
    rad_nxt  = {rad_r[2*ROOT_W-3:0], 2'b00};
  end

  // Control: load on start, count the steps, pulse done after the last
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= ITERS;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: shift the radicand out, build the root one bit a step
  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r  <= rad_nxt;
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end
  end

  // Round up when the remainder exceeds the floor root
  assign root = {1'b0, root_r} + (ROOT_W+1)'(rem_r > {1'b0, root_r});

  assign stat.busy = busy_r;
  assign stat.done = done_r;

  `CTL_ASSERT(a_start_busy, clk, rst_n, start |=> busy_r, "root unit did not start")
  `CTL_ASSERT(a_done_after_busy, clk, rst_n, done_r |-> ($past(busy_r) && !busy_r),
              "done without a finished run")
  `CTL_ASSERT(a_busy_count, clk, rst_n, busy_r |-> (cnt_r != '0), "busy with no steps left")

endmodule

FILE: sim/tour_length_checker.sv
// Checker for closed_tour_length: watches both channels, predicts each tour total and compares.
// Depends on ctl_pkg for the default coordinate and total widths.
module tour_length_checker import ctl_pkg::*; (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic                             in_stall,
  input  logic signed [COORD_BITS_DEF-1:0] in_x_coord,
  input  logic signed [COORD_BITS_DEF-1:0] in_y_coord,
  input  logic                             in_last_city,
  input  logic                             out_valid,
  input  logic                             out_stall,
  input  logic [TOTAL_BITS_DEF-1:0]        out_total,
  input  logic                             out_saturated,
  input  bit                               drain_done,
  output int                               fail_count,
  output int                               pending_results
);

  localparam int CW = COORD_BITS_DEF;
  localparam int TW = TOTAL_BITS_DEF;

  typedef struct packed {
    logic [TW-1:0] length;
    logic          clamped;
  } tour_result_t;

  // Totals of finished tours, oldest first
  tour_result_t tour_totals_q[$];

  // Own copy of the tour state
  logic signed [CW-1:0] start_x, start_y, prev_x, prev_y;
  logic [TW-1:0]        length_sum;
  logic                 sum_clamped;
  logic                 tour_open;
  bit                   leftovers_done;

  // Floor of the square root, digit by digit
  function automatic logic [63:0] floor_root(input logic [63:0] s);
    logic [63:0] rem;
    logic [63:0] root;
    logic [63:0] bitv;
    rem  = s;
    root = '0;
    bitv = 64'h4000_0000_0000_0000;
    while (bitv > s) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem  = rem - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // Euclidean distance between two cities, rounded to the nearest integer
  function automatic logic [TW-1:0] rounded_distance(
    input logic signed [CW-1:0] ax, input logic signed [CW-1:0] ay,
    input logic signed [CW-1:0] bx, input logic signed [CW-1:0] by
  );
    logic signed [CW:0] dx, dy;
    logic [CW:0]        ux, uy;
    logic [63:0]        sq, root;
    dx = {ax[CW-1], ax} - {bx[CW-1], bx};
    dy = {ay[CW-1], ay} - {by[CW-1], by};
    ux = dx[CW] ? -dx : dx;
    uy = dy[CW] ? -dy : dy;
    sq = 64'(ux) * 64'(ux) + 64'(uy) * 64'(uy);
    root = floor_root(sq);
    if (sq - root * root > root) root = root + 1;
    return TW'(root);
  endfunction

  // Add one edge, clamping the total at all ones
  task automatic add_edge_length(input logic [TW-1:0] len);
    logic [TW:0] sum;
    sum = {1'b0, length_sum} + {1'b0, len};
    if (sum[TW]) begin
      length_sum  = '1;
      sum_clamped = 1'b1;
    end else begin
      length_sum = sum[TW-1:0];
    end
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("[%0t] %s: got %0d, want %0d", $time, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    tour_result_t want;
    if (!rst_n) begin
      start_x         = '0;
      start_y         = '0;
      prev_x          = '0;
      prev_y          = '0;
      length_sum      = '0;
      sum_clamped     = 1'b0;
      tour_open       = 1'b0;
      leftovers_done  = 1'b0;
      fail_count      = 0;
      tour_totals_q.delete();
      pending_results = 0;
    end else begin
      // Compare an accepted result with the oldest tour total
      if (out_valid && !out_stall) begin
        if (tour_totals_q.size() == 0) begin
          report_mismatch("result with no tour pending", 64'(out_total), 64'(0));
        end else begin
          want = tour_totals_q.pop_front();
          if (out_total !== want.length)
            report_mismatch("total", 64'(out_total), 64'(want.length));
          if (out_saturated !== want.clamped)
            report_mismatch("saturated", 64'(out_saturated), 64'(want.clamped));
        end
      end

      // Advance the tour state on an accepted city
      if (in_valid && !in_stall) begin
        if (!tour_open) begin
          start_x     = in_x_coord;
          start_y     = in_y_coord;
          length_sum  = '0;
          sum_clamped = 1'b0;
          tour_open   = 1'b1;
        end else begin
          add_edge_length(rounded_distance(in_x_coord, in_y_coord, prev_x, prev_y));
        end
        prev_x = in_x_coord;
        prev_y = in_y_coord;
        if (in_last_city) begin
          add_edge_length(rounded_distance(start_x, start_y, in_x_coord, in_y_coord));
          want.length  = length_sum;
          want.clamped = sum_clamped;
          tour_totals_q.push_back(want);
          tour_open = 1'b0;
        end
      end

      // Flag every tour total still waiting at the end
      if (drain_done && !leftovers_done) begin
        leftovers_done = 1'b1;
        while (tour_totals_q.size() != 0) begin
          want = tour_totals_q.pop_front();
          report_mismatch("tour total never delivered", 64'(0), 64'(want.length));
        end
      end
      pending_results = tour_totals_q.size();
    end
  end

endmodule

FILE: sim/testbench.sv
// Top of the closed_tour_length simulation: clock, reset, city stimulus and verdict.
// Depends on ctl_pkg, closed_tour_length and tour_length_checker.
module testbench;
  import ctl_pkg::*;

  localparam int CW                  = COORD_BITS_DEF;
  localparam int TW                  = TOTAL_BITS_DEF;
  localparam int RANDOM_ITEMS        = 1400;
  localparam int HOLD_OFF_CYCLES     = 600;
  localparam int DRAIN_CYCLES        = 100;
  localparam int WATCHDOG_LIMIT      = 5000;
  localparam logic signed [CW-1:0] COORD_MIN = {1'b1, {(CW-1){1'b0}}};
  localparam logic signed [CW-1:0] COORD_MAX = {1'b0, {(CW-1){1'b1}}};

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic signed [CW-1:0] in_x_coord;
  logic signed [CW-1:0] in_y_coord;
  logic                 in_last_city;
  logic                 out_valid;
  logic                 out_stall;
  logic [TW-1:0]        out_total;
  logic                 out_saturated;

  bit drain_done;
  bit hold_off_req;
  bit quiet_sender;
  int fail_count;
  int pending_results;
  int cities_sent;
  int idle_cycles;

  closed_tour_length i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_x_coord    (in_x_coord),
    .in_y_coord    (in_y_coord),
    .in_last_city  (in_last_city),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_total     (out_total),
    .out_saturated (out_saturated)
  );

  tour_length_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_x_coord      (in_x_coord),
    .in_y_coord      (in_y_coord),
    .in_last_city    (in_last_city),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_total       (out_total),
    .out_saturated   (out_saturated),
    .drain_done      (drain_done),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Gap after a city: mostly none, some short, a few long
  function automatic int sender_gap();
    int r;
    if (quiet_sender) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 4);
    return $urandom_range(15, 70);
  endfunction

  // Coordinate drawn from full range, near zero or at the extremes
  function automatic logic signed [CW-1:0] pick_coord();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return CW'($urandom);
    if (r < 8) return CW'(int'($urandom_range(0, 2000)) - 1000);
    if (r == 8) return $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
    return $urandom_range(0, 1) ? COORD_MAX - CW'($urandom_range(0, 15))
                                : COORD_MIN + CW'($urandom_range(0, 15));
  endfunction

  // Offer one city and hold it until accepted
  task automatic send_city(input logic signed [CW-1:0] x, input logic signed [CW-1:0] y,
                           input logic last);
    int gap;
    @(negedge clk);
    in_x_coord   = x;
    in_y_coord   = y;
    in_last_city = last;
    in_valid     = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    cities_sent++;
    gap = sender_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid     = 1'b0;
      in_x_coord   = CW'($urandom);
      in_y_coord   = CW'($urandom);
      in_last_city = 1'($urandom_range(0, 1));
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Receiver: random stalls, quiet stretches and one long hold-off
  initial begin
    int stall_left;
    int phase_cycles;
    bit quiet;
    bit hold_done;
    out_stall    = 1'b0;
    stall_left   = 0;
    phase_cycles = 0;
    quiet        = 1'b0;
    hold_done    = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req && !hold_done) begin
        hold_done  = 1'b1;
        stall_left = HOLD_OFF_CYCLES;
      end
      phase_cycles++;
      if (phase_cycles == 250) begin
        phase_cycles = 0;
        quiet = ($urandom_range(0, 3) == 0);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall = 1'b1;
      end else if (!quiet && $urandom_range(0, 99) < 12) begin
        stall_left = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2)
                                                  : $urandom_range(19, 79);
        out_stall = 1'b1;
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles = 0;
    end else begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Stimulus and verdict
  initial begin
    int tour_count;
    int tour_len;
    int r;
    bit sat_tour;
    logic signed [CW-1:0] jx, jy;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_x_coord   = '0;
    in_y_coord   = '0;
    in_last_city = 1'b0;
    drain_done   = 1'b0;
    hold_off_req = 1'b0;
    quiet_sender = 1'b0;
    cities_sent  = 0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // Single-city tours, at the origin and at the extremes
    send_city('0, '0, 1'b1);
    send_city(COORD_MIN, COORD_MAX, 1'b1);
    // Exact right triangle edge, there and back
    send_city('0, '0, 1'b0);
    send_city(CW'(3), CW'(4), 1'b1);
    // Longest possible edge
    send_city(COORD_MIN, COORD_MIN, 1'b0);
    send_city(COORD_MAX, COORD_MAX, 1'b1);
    // Rounding of irrational edges
    send_city('0, '0, 1'b0);
    send_city(CW'(1), CW'(1), 1'b0);
    send_city(CW'(2), '0, 1'b1);
    send_city('0, '0, 1'b0);
    send_city(CW'(2), CW'(1), 1'b1);
    // Corners of the grid
    send_city(COORD_MIN, COORD_MIN, 1'b0);
    send_city(COORD_MAX, COORD_MIN, 1'b0);
    send_city(COORD_MAX, COORD_MAX, 1'b0);
    send_city(COORD_MIN, COORD_MAX, 1'b1);
    send_city(COORD_MAX, COORD_MIN, 1'b0);
    send_city(COORD_MIN, COORD_MAX, 1'b1);

    // Random tours, with a few long ones that drive the total into saturation
    cities_sent = 0;
    tour_count  = 0;
    while (cities_sent < RANDOM_ITEMS) begin
      quiet_sender = ($urandom_range(0, 3) == 0);
      if (tour_count == 20) hold_off_req = 1'b1;
      sat_tour = (tour_count == 3) || ($urandom_range(0, 99) == 0);
      if (sat_tour) begin
        tour_len = $urandom_range(185, 220);
        for (int k = 0; k < tour_len; k++) begin
          jx = CW'($urandom_range(0, 255));
          jy = CW'($urandom_range(0, 255));
          if (k % 2 == 0)
            send_city(COORD_MIN + jx, COORD_MIN + jy, k == tour_len - 1);
          else
            send_city(COORD_MAX - jx, COORD_MAX - jy, k == tour_len - 1);
        end
      end else begin
        r = $urandom_range(0, 99);
        if (r < 15)
          tour_len = 1;
        else if (r < 85)
          tour_len = $urandom_range(2, 8);
        else
          tour_len = $urandom_range(9, 40);
        for (int k = 0; k < tour_len; k++)
          send_city(pick_coord(), pick_coord(), k == tour_len - 1);
      end
      tour_count++;
    end

    // Drop valid, let every tour total arrive, then allow for stragglers
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    drain_done = 1'b1;
    @(negedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+src
src/ctl_pkg.sv
src/ctl_isqrt.sv
src/closed_tour_length.sv
sim/tour_length_checker.sv
sim/testbench.sv
